/* design/contact_impulse_resolver_defines.svh */
// Assertion macros used by the checker file.
`ifndef CONTACT_IMPULSE_RESOLVER_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CIR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("contact_impulse_resolver: assertion failed");

// Next-cycle implication, disabled in reset.
`define CIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("contact_impulse_resolver: assertion failed");

`endif

/* design/cir_pkg.sv */
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types and constants of the contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

   localparam int BODY_COUNT = 64;
   localparam int IDX_W      = $clog2(BODY_COUNT);
   localparam int VEL_W      = 16;
   localparam int INV_W      = 16;
   localparam int BNC_W      = 9;
   localparam logic [BNC_W-1:0] BNC_ONE = 9'd256;
   localparam int DOT_W      = 35;   // relative velocity dot normal, Q.22
   localparam int NUM_W      = 45;   // (256 + e) * -vn, Q.30
   localparam int QUO_W      = 37;   // impulse j, Q.14
   localparam int DEN_W      = 17;   // invA + invB
   localparam int TN_W       = 47;   // clamped j * n
   localparam int PRD_W      = 64;   // j * n * inv, Q.36
   localparam int RND_SH     = 28;
   localparam int DV_W       = PRD_W - RND_SH;
   localparam int SUM_W      = DV_W + 1;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_CONTACT = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUT_NONE      = 2'd0,
      OUT_APPLIED   = 2'd1,
      OUT_STUCK     = 2'd2,
      OUT_SATURATED = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDA,
      ST_RDB,
      ST_CAPB,
      ST_DOT,
      ST_CHK,
      ST_DIV,
      ST_MULN,
      ST_MULM,
      ST_APPLY,
      ST_WRA,
      ST_WRB,
      ST_FIN
   } state_type;

endpackage

/* design/cir_div.sv */
// ----------------------------------------------------------------------------
// cir_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module cir_div
   import cir_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QUO_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [QUO_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[QUO_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
         rem_ff <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/contact_impulse_resolver.sv */
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// Body table with impulse-based contact response, write and read of bodies.
// ----------------------------------------------------------------------------
//  channel   ports   direction   carries
//  request   req_*   in          operation, bodies, vector, inverse mass, bounce
//  response  rsp_*   out         velocities of A and B, outcome
//
//  States from one accept to the next: write FIN; read RDA, RDB, FIN; contact RDA,
//  RDB, CAPB, 3 dot-product steps, CHK, a serial divide for 37 quotient bits, MULN,
//  MULM and APPLY per component and body for the two multiplies and the saturating
//  update, plus the writebacks WRA, WRB and FIN; the response shows as req_ready rises.
//  The serial divider takes the larger part of a contact.
//  Reset clears control only; the body memories hold garbage until written.
//  A new request is taken while a finished response still waits on rsp_ready.
// ----------------------------------------------------------------------------
module contact_impulse_resolver
   import cir_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_operation,
   input  logic [IDX_W-1:0]        req_body_a,
   input  logic [IDX_W-1:0]        req_body_b,
   input  logic signed [VEL_W-1:0] req_vec_x,
   input  logic signed [VEL_W-1:0] req_vec_y,
   input  logic signed [VEL_W-1:0] req_vec_z,
   input  logic [INV_W-1:0]        req_inverse_mass,
   input  logic [BNC_W-1:0]        req_bounce,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VEL_W-1:0] rsp_vel_a_x,
   output logic signed [VEL_W-1:0] rsp_vel_a_y,
   output logic signed [VEL_W-1:0] rsp_vel_a_z,
   output logic signed [VEL_W-1:0] rsp_vel_b_x,
   output logic signed [VEL_W-1:0] rsp_vel_b_y,
   output logic signed [VEL_W-1:0] rsp_vel_b_z,
   output logic [1:0]              rsp_outcome
);

   localparam int VEC_W = 3 * VEL_W;
   localparam int MB_W  = INV_W + BNC_W;
   localparam logic signed [QUO_W+VEL_W:0] PAIR_MAX = (QUO_W+VEL_W+1)'(64'sd1 <<< 45);

   // body memories
   logic [VEC_W-1:0] vel_mem [BODY_COUNT];
   logic [MB_W-1:0]  mb_mem  [BODY_COUNT];
   logic [VEC_W-1:0] rd_vel_ff;
   logic [MB_W-1:0]  rd_mb_ff;

   state_type state_ff, state_in;

   // request latch
   op_type              op_ff;
   logic [IDX_W-1:0]    a_ff, b_ff;
   logic signed [VEL_W-1:0] n_ff  [3];
   logic signed [VEL_W-1:0] va_ff [3];
   logic signed [VEL_W-1:0] vb_ff [3];
   logic [INV_W-1:0]    inv_a_ff, inv_b_ff;
   logic [BNC_W-1:0]    e_a_ff, e_b_ff;
   logic signed [DOT_W-1:0] vn_ff;
   logic [QUO_W-1:0]    j_ff;
   logic signed [TN_W-1:0]  tn_ff;
   logic signed [PRD_W-1:0] p_ff;
   logic [1:0]          comp_ff;
   logic                side_ff;
   logic                hit_ff;
   outcome_type         outcome_ff;

   // response register
   logic                rsp_valid_ff;
   logic signed [VEL_W-1:0] ova_ff [3];
   logic signed [VEL_W-1:0] ovb_ff [3];
   outcome_type         oout_ff;

   // control
   logic             accept;
   logic             vel_we;
   logic [IDX_W-1:0] vel_waddr;
   logic [VEC_W-1:0] vel_wdata;
   logic             mb_we;
   logic [IDX_W-1:0] rd_addr;
   logic             div_start;
   logic             div_done;
   logic [QUO_W-1:0] div_quo;
   logic             rsp_load;

   // datapath
   logic signed [VEL_W:0]       rel;
   logic signed [2*VEL_W:0]     dot_term;
   logic [BNC_W-1:0]            e_min;
   logic [DOT_W-1:0]            vn_mag;
   logic [NUM_W-1:0]            num;
   logic [DEN_W-1:0]            den;
   logic                        separating;
   logic signed [QUO_W+VEL_W:0] jn;
   logic [INV_W-1:0]            inv_sel;
   logic [PRD_W-1:0]            p_mag;
   logic [PRD_W-1:0]            p_rnd;
   logic signed [SUM_W-1:0]     dv;
   logic signed [VEL_W-1:0]     cur;
   logic signed [SUM_W-1:0]     upd;
   logic signed [VEL_W-1:0]     upd_sat;
   logic                        upd_hit;
   logic [BNC_W-1:0]            bnc_clip;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // --- arithmetic -----------------------------------------------------------
   assign rel      = $signed({vb_ff[comp_ff][VEL_W-1], vb_ff[comp_ff]})
                   - $signed({va_ff[comp_ff][VEL_W-1], va_ff[comp_ff]});
   assign dot_term = rel * n_ff[comp_ff];

   assign e_min      = (e_a_ff < e_b_ff) ? e_a_ff : e_b_ff;
   assign vn_mag     = DOT_W'(-vn_ff);
   assign num        = NUM_W'(({1'b0, e_min} + 10'd256) * vn_mag);
   assign den        = {1'b0, inv_a_ff} + {1'b0, inv_b_ff};
   assign separating = !vn_ff[DOT_W-1] && (vn_ff != '0);

   assign jn      = $signed({1'b0, j_ff}) * n_ff[comp_ff];
   assign inv_sel = side_ff ? inv_b_ff : inv_a_ff;

   // round to nearest, ties away from zero, then signed delta
   assign p_mag = p_ff[PRD_W-1] ? PRD_W'(-p_ff) : PRD_W'(p_ff);
   assign p_rnd = p_mag + (PRD_W'(1) << (RND_SH - 1));
   assign dv    = p_ff[PRD_W-1] ? -$signed({1'b0, p_rnd[PRD_W-1:RND_SH]})
                                :  $signed({1'b0, p_rnd[PRD_W-1:RND_SH]});
   assign cur   = side_ff ? vb_ff[comp_ff] : va_ff[comp_ff];
   assign upd   = side_ff ? SUM_W'(cur) + dv : SUM_W'(cur) - dv;

   always_comb begin
      upd_hit = 1'b0;
      upd_sat = upd[VEL_W-1:0];
      if (upd > SUM_W'(32767)) begin
         upd_hit = 1'b1;
         upd_sat = 16'sh7fff;
      end else if (upd < -SUM_W'(32768)) begin
         upd_hit = 1'b1;
         upd_sat = -16'sh8000;
      end
   end

   assign bnc_clip = (req_bounce > BNC_ONE) ? BNC_ONE : req_bounce;

   // --- next state and memory control ----------------------------------------
   always_comb begin
      state_in  = state_ff;
      vel_we    = 1'b0;
      vel_waddr = a_ff;
      vel_wdata = {va_ff[2], va_ff[1], va_ff[0]};
      mb_we     = 1'b0;
      rd_addr   = a_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            vel_waddr = req_body_a;
            vel_wdata = {req_vec_z, req_vec_y, req_vec_x};
            if (accept) begin
               case (op_type'(req_operation))
                  OP_WRITE: begin
                     vel_we   = 1'b1;
                     mb_we    = 1'b1;
                     state_in = ST_FIN;
                  end
                  OP_CONTACT: state_in = ST_RDA;
                  OP_READ:    state_in = ST_RDA;
                  default:    state_in = ST_FIN;
               endcase
            end
         end
         ST_RDA:  state_in = ST_RDB;
         ST_RDB: begin
            rd_addr  = b_ff;
            state_in = (op_ff == OP_READ) ? ST_FIN : ST_CAPB;
         end
         ST_CAPB: state_in = ST_DOT;
         ST_DOT:  if (comp_ff == 2'd2) state_in = ST_CHK;
         ST_CHK: begin
            if (separating || den == '0) begin
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV:  if (div_done) state_in = ST_MULN;
         ST_MULN: state_in = ST_MULM;
         ST_MULM: state_in = ST_APPLY;
         ST_APPLY: begin
            if (comp_ff == 2'd2) begin
               state_in = side_ff ? ST_WRB : ST_WRA;
            end else begin
               state_in = ST_MULN;
            end
         end
         ST_WRA: begin
            vel_we   = 1'b1;
            state_in = ST_MULN;
         end
         ST_WRB: begin
            vel_we    = 1'b1;
            vel_waddr = b_ff;
            vel_wdata = {vb_ff[2], vb_ff[1], vb_ff[0]};
            state_in  = ST_FIN;
         end
         ST_FIN:  if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --- memories ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (vel_we) begin
         vel_mem[vel_waddr] <= vel_wdata;
      end
      rd_vel_ff <= vel_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mb_we) begin
         mb_mem[req_body_a] <= {req_inverse_mass, bnc_clip};
      end
      rd_mb_ff <= mb_mem[rd_addr];
   end

   // --- divider ------------------------------------------------------------------
   cir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num[NUM_W-1:NUM_W-QUO_W]),
      .divisor  (den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // --- datapath registers -------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_ff      <= op_type'(req_operation);
               a_ff       <= req_body_a;
               b_ff       <= req_body_b;
               n_ff[0]    <= req_vec_x;
               n_ff[1]    <= req_vec_y;
               n_ff[2]    <= req_vec_z;
               outcome_ff <= OUT_NONE;
               for (int i = 0; i < 3; i++) begin
                  vb_ff[i] <= '0;
               end
               if (op_type'(req_operation) == OP_WRITE) begin
                  va_ff[0] <= req_vec_x;
                  va_ff[1] <= req_vec_y;
                  va_ff[2] <= req_vec_z;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     va_ff[i] <= '0;
                  end
               end
            end
         end
         ST_RDB: begin
            for (int i = 0; i < 3; i++) begin
               va_ff[i] <= rd_vel_ff[i*VEL_W +: VEL_W];
            end
            inv_a_ff <= rd_mb_ff[MB_W-1:BNC_W];
            e_a_ff   <= rd_mb_ff[BNC_W-1:0];
         end
         ST_CAPB: begin
            for (int i = 0; i < 3; i++) begin
               vb_ff[i] <= rd_vel_ff[i*VEL_W +: VEL_W];
            end
            inv_b_ff <= rd_mb_ff[MB_W-1:BNC_W];
            e_b_ff   <= rd_mb_ff[BNC_W-1:0];
            vn_ff    <= '0;
            comp_ff  <= 2'd0;
         end
         ST_DOT: begin
            vn_ff   <= vn_ff + DOT_W'(dot_term);
            comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
         end
         ST_CHK: begin
            hit_ff  <= 1'b0;
            side_ff <= 1'b0;
            comp_ff <= 2'd0;
            if (separating) begin
               outcome_ff <= OUT_NONE;
            end else if (den == '0) begin
               outcome_ff <= OUT_STUCK;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               j_ff <= div_quo;
            end
         end
         ST_MULN: begin
            if (jn > PAIR_MAX) begin
               tn_ff <= TN_W'(PAIR_MAX);
            end else if (jn < -PAIR_MAX) begin
               tn_ff <= TN_W'(-PAIR_MAX);
            end else begin
               tn_ff <= TN_W'(jn);
            end
         end
         ST_MULM: begin
            p_ff <= PRD_W'(tn_ff * $signed({1'b0, inv_sel}));
         end
         ST_APPLY: begin
            if (side_ff) begin
               vb_ff[comp_ff] <= upd_sat;
            end else begin
               va_ff[comp_ff] <= upd_sat;
            end
            hit_ff  <= hit_ff | upd_hit;
            comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
         end
         ST_WRA: begin
            // same body on both sides: B starts from the updated entry
            if (a_ff == b_ff) begin
               for (int i = 0; i < 3; i++) begin
                  vb_ff[i] <= va_ff[i];
               end
            end
            side_ff <= 1'b1;
         end
         ST_WRB: begin
            outcome_ff <= hit_ff ? OUT_SATURATED : OUT_APPLIED;
         end
         default: begin
         end
      endcase
   end

   // --- response register ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int i = 0; i < 3; i++) begin
            ova_ff[i] <= va_ff[i];
            ovb_ff[i] <= vb_ff[i];
         end
         oout_ff <= outcome_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vel_a_x = ova_ff[0];
   assign rsp_vel_a_y = ova_ff[1];
   assign rsp_vel_a_z = ova_ff[2];
   assign rsp_vel_b_x = ovb_ff[0];
   assign rsp_vel_b_y = ovb_ff[1];
   assign rsp_vel_b_z = ovb_ff[2];
   assign rsp_outcome = oout_ff;

endmodule

/* design/cir_checker.sv */
// ----------------------------------------------------------------------------
// cir_checker
// Port-level checks of the contact impulse resolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "contact_impulse_resolver_defines.svh"

module cir_checker
   import cir_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_outcome
);

   // one request in flight: busy right after a request is taken
   `CIR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // no stale response after reset
   `CIR_ASSERT_IMPL(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)
   // stalled response stays
   `CIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CIR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_outcome))

endmodule

bind contact_impulse_resolver cir_checker u_cir_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_outcome (rsp_outcome)
);

/* verif/contact_impulse_resolver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_impulse_resolver_tb
// Drives body writes, reads and contacts through the request channel, keeps a
// shadow body table with its own impulse arithmetic and checks every response
// field against it, under random idling on both channels in most phases.
// ----------------------------------------------------------------------------
module contact_impulse_resolver_tb
   import cir_pkg::*;
();

   typedef struct {
      logic signed [15:0] ax, ay, az, bx, by, bz;
      logic [1:0]         outcome;
   } vel_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_WRITE;
   logic [IDX_W-1:0] req_body_a = '0, req_body_b = '0;
   logic signed [VEL_W-1:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic [INV_W-1:0] req_inverse_mass = '0;
   logic [BNC_W-1:0] req_bounce = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VEL_W-1:0] rsp_vel_a_x, rsp_vel_a_y, rsp_vel_a_z;
   logic signed [VEL_W-1:0] rsp_vel_b_x, rsp_vel_b_y, rsp_vel_b_z;
   logic [1:0] rsp_outcome;

   contact_impulse_resolver dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow body table
   logic signed [15:0] shadow_vel [BODY_COUNT][3];
   logic [15:0] shadow_inv [BODY_COUNT];
   logic [8:0]  shadow_bounce [BODY_COUNT];
   bit          written [BODY_COUNT];

   vel_pair_type expected_velocities [$];
   int mismatches = 0;
   int cycle_count = 0;
   bit idle_enable = 1'b1;   // random idling on both sides
   bit hold_rsp = 1'b0;      // long receiver hold-off
   int hold_cycles = 0;
   int rsp_idle = 0;

   function automatic logic signed [15:0] clip16(longint v, ref bit hit);
      if (v > 32767) begin
         hit = 1; return 16'sd32767;
      end
      if (v < -32768) begin
         hit = 1; return -16'sd32768;
      end
      return v[15:0];
   endfunction

   // j * n (clamped) * inv in Q.36 rounded to Q8.8, ties away from zero
   function automatic longint impulse_step(longint j, longint n, longint inv);
      longint t, p, m;
      t = j * n;
      if (t > (64'sd1 <<< 45)) t = 64'sd1 <<< 45;
      if (t < -(64'sd1 <<< 45)) t = -(64'sd1 <<< 45);
      p = t * inv;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 <<< 27)) >>> 28;
      return (p < 0) ? -m : m;
   endfunction

   function automatic vel_pair_type resolve_request(logic [1:0] op, int a, int b,
         logic signed [15:0] vx, logic signed [15:0] vy, logic signed [15:0] vz,
         logic [15:0] inv, logic [8:0] bn);
      vel_pair_type r;
      longint n [3];
      longint vn, num, j, den;
      int e;
      bit hit;
      r = '{0, 0, 0, 0, 0, 0, OUT_NONE};
      n[0] = longint'(vx); n[1] = longint'(vy); n[2] = longint'(vz);
      hit = 0;
      case (op)
         OP_WRITE: begin
            shadow_vel[a][0] = vx; shadow_vel[a][1] = vy; shadow_vel[a][2] = vz;
            shadow_inv[a] = inv;
            shadow_bounce[a] = (bn > 256) ? 9'd256 : bn;
            written[a] = 1;
            r.ax = vx; r.ay = vy; r.az = vz;
         end
         OP_READ: begin
            r.ax = shadow_vel[a][0]; r.ay = shadow_vel[a][1]; r.az = shadow_vel[a][2];
         end
         OP_CONTACT: begin
            vn = 0;
            for (int i = 0; i < 3; i++)
               vn += (longint'(shadow_vel[b][i]) - longint'(shadow_vel[a][i])) * n[i];
            den = longint'(shadow_inv[a]) + longint'(shadow_inv[b]);
            if (vn > 0) r.outcome = OUT_NONE;
            else if (den == 0) r.outcome = OUT_STUCK;
            else begin
               e = int'((shadow_bounce[a] < shadow_bounce[b]) ? shadow_bounce[a]
                                                              : shadow_bounce[b]);
               num = (256 + e) * (-vn);
               j = num / (den <<< 8);
               for (int i = 0; i < 3; i++)
                  shadow_vel[a][i] = clip16(longint'(shadow_vel[a][i])
                     - impulse_step(j, n[i], longint'(shadow_inv[a])), hit);
               r.ax = shadow_vel[a][0]; r.ay = shadow_vel[a][1]; r.az = shadow_vel[a][2];
               for (int i = 0; i < 3; i++)
                  shadow_vel[b][i] = clip16(longint'(shadow_vel[b][i])
                     + impulse_step(j, n[i], longint'(shadow_inv[b])), hit);
               r.bx = shadow_vel[b][0]; r.by = shadow_vel[b][1]; r.bz = shadow_vel[b][2];
               r.outcome = hit ? OUT_SATURATED : OUT_APPLIED;
               return r;
            end
            r.ax = shadow_vel[a][0]; r.ay = shadow_vel[a][1]; r.az = shadow_vel[a][2];
            r.bx = shadow_vel[b][0]; r.by = shadow_vel[b][1]; r.bz = shadow_vel[b][2];
         end
         default: ;
      endcase
      return r;
   endfunction

   // now and then drop valid and wait a random number of cycles while idling is enabled
   task automatic idle_burst();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   // offer one request and hold it until accepted
   task automatic send_request(logic [1:0] op, int a, int b, int vx, int vy, int vz,
         int inv, int bn);
      logic [IDX_W-1:0] ia, ib;
      logic [VEL_W-1:0] x, y, z;
      logic [INV_W-1:0] im;
      logic [BNC_W-1:0] bc;
      vel_pair_type     exp_item;
      ia = IDX_W'(a); ib = IDX_W'(b);
      x = VEL_W'(vx); y = VEL_W'(vy); z = VEL_W'(vz);
      im = INV_W'(inv); bc = BNC_W'(bn);
      idle_burst();
      req_valid <= 1'b1;
      req_operation <= op;
      req_body_a <= ia; req_body_b <= ib;
      req_vec_x <= x; req_vec_y <= y; req_vec_z <= z;
      req_inverse_mass <= im; req_bounce <= bc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_item = resolve_request(op, int'(ia), int'(ib), x, y, z, im, bc);
      expected_velocities.insert(expected_velocities.size(), exp_item);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_velocities.size() != 0) @(negedge clock);
   endtask

   function automatic int pick_written();
      int k;
      do k = $urandom_range(0, BODY_COUNT - 1); while (!written[k]);
      return k;
   endfunction

   task automatic write_random_body(int a);
      send_request(OP_WRITE, a, $urandom, $urandom_range(0, 2000) - 1000,
         $urandom_range(0, 2000) - 1000, $urandom, $urandom_range(0, 3) == 0 ?
         0 : $urandom_range(0, 1024), $urandom_range(0, 300));
   endtask

   // receiver: random idle bursts, plus a counted long hold-off
   always @(negedge clock) begin
      if (!hold_rsp) hold_cycles <= 0;
      if (hold_rsp && hold_cycles < 300) begin
         hold_cycles <= hold_cycles + 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && rsp_idle > 0) begin
         rsp_idle <= rsp_idle - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_idle <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= 1'b1;
   end

   // response checker
   always @(posedge clock) begin
      vel_pair_type exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_velocities.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at cycle %0d", cycle_count);
         end else begin
            exp_r = expected_velocities.pop_front();
            if (rsp_vel_a_x !== exp_r.ax || rsp_vel_a_y !== exp_r.ay ||
                rsp_vel_a_z !== exp_r.az || rsp_vel_b_x !== exp_r.bx ||
                rsp_vel_b_y !== exp_r.by || rsp_vel_b_z !== exp_r.bz ||
                rsp_outcome !== exp_r.outcome) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp a=%0d,%0d,%0d b=%0d,%0d,%0d o=%0d got a=%0d,%0d,%0d b=%0d,%0d,%0d o=%0d",
                     exp_r.ax, exp_r.ay, exp_r.az, exp_r.bx, exp_r.by, exp_r.bz, exp_r.outcome,
                     rsp_vel_a_x, rsp_vel_a_y, rsp_vel_a_z, rsp_vel_b_x, rsp_vel_b_y,
                     rsp_vel_b_z, rsp_outcome);
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // corner cases: field extremes, bounce clamp, stuck, separating, same body
   task automatic test_directed();
      send_request(OP_WRITE, 0, 0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 9'd511);
      send_request(OP_WRITE, 63, 63, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 9'd0);
      send_request(OP_WRITE, 1, 0, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 9'd256);
      send_request(OP_WRITE, 2, 0, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 9'd128);
      send_request(OP_WRITE, 3, 0, 16'h0200, 16'h0000, 16'h0000, 16'h0100, 9'd200);
      send_request(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      send_request(OP_READ, 63, 0, 0, 0, 0, 0, 0);
      send_request(OP_CONTACT, 1, 2, 16'h4000, 0, 0, 0, 0);   // both immovable
      send_request(OP_CONTACT, 2, 1, 16'h4000, 0, 0, 0, 0);   // separating
      send_request(OP_CONTACT, 1, 3, 16'h4000, 0, 0, 0, 0);   // separating, B faster along n
      send_request(OP_CONTACT, 0, 63, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0); // saturation
      send_request(OP_CONTACT, 3, 3, 16'h4000, 16'h4000, 0, 0, 0);          // same body
      send_request(OP_CONTACT, 0, 3, 16'h0000, 16'h0000, 16'h0000, 0, 0);   // zero normal
      send_request(OP_NONE, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF);
      send_request(OP_READ, 3, 0, 0, 0, 0, 0, 0);
   endtask

   // random mix of writes, reads, no-ops and ten-pass contact replays
   task automatic test_random(int count);
      int a, b, kind;
      int nx, ny, nz;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 2) write_random_body($urandom_range(0, BODY_COUNT - 1));
         else if (kind < 4) send_request(OP_READ, pick_written(), $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
         else if (kind == 4) send_request(OP_NONE, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
         else begin
            a = pick_written(); b = pick_written();
            nx = $urandom_range(0, 1) ? 16384 - $urandom_range(0, 8000) : $urandom;
            ny = $urandom_range(0, 32767) - 16384; nz = $urandom;
            for (int p = 0; p < 10 && i < count; p++, i++)
               send_request(OP_CONTACT, a, b, nx, ny, nz, $urandom, $urandom);
         end
      end
   endtask

   // receiver stalls long while requests keep coming
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      test_random(30);
      hold_rsp = 1'b0;
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain();   // sender pause until every response is in
      for (int k = 0; k < BODY_COUNT; k++) write_random_body(k);
      test_random(350);
      test_backpressure();
      test_random(250);
      idle_enable = 1'b0;
      test_random(120);
      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_velocities.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
